FILE: design/l1bp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the l1 beta/phi split block
// no dependencies

package l1bp_pkg;

  localparam int DATA_W = 32;
  localparam int LAM_W  = 31;
  localparam int MAG_W  = 31;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 192;
  localparam int CLS_W  = 2;

  typedef enum logic [CLS_W-1:0] {
    CLS_ZERO_BETA = 2'd0,
    CLS_POS_PHI   = 2'd1,
    CLS_NEG_PHI   = 2'd2,
    CLS_UNSEL     = 2'd3
  } cls_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic sel;
    logic square;
    logic accum;
    logic root_start;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic root_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: design/l1bp_isqrt.sv
`timescale 1ns / 1ps
// iterative 64-bit integer square root; a new start restarts the computation
// depends on l1bp_pkg

module l1bp_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [l1bp_pkg::SUM_W-1:0]    operand,
  output logic                          busy,
  output logic [l1bp_pkg::ROOT_W-1:0]   root
);

  localparam int SW = l1bp_pkg::SUM_W;

  logic          busy_r, busy_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] res_r, res_nxt;
  logic [SW-1:0] bit_r, bit_nxt;
  logic [SW-1:0] trial;
  logic          fits;

  always_comb begin
    trial    = res_r + bit_r;
    fits     = rem_r >= trial;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = operand;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(SW-2){1'b0}}};
    end else if (busy_r) begin
      rem_nxt = fits ? rem_r - trial : rem_r;
      res_nxt = fits ? (res_r >> 1) + bit_r : res_r >> 1;
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[l1bp_pkg::ROOT_W-1:0];

endmodule

FILE: design/l1bp_datapath.sv
`timescale 1ns / 1ps
// datapath: classification, step value, squares, sums, counters, square roots, output register
// depends on l1bp_pkg and l1bp_isqrt

module l1bp_datapath #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [l1bp_pkg::LAM_W-1:0]       cfg_wr_data,
  input  logic [l1bp_pkg::IN_W-1:0]        in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [l1bp_pkg::OUT_W-1:0]       out_tdata,
  output logic [l1bp_pkg::CLS_W-1:0]       out_tuser,
  output logic                             out_tlast,
  input  l1bp_pkg::ctrl_cmd_t              cmd,
  output l1bp_pkg::ctrl_sts_t              sts
);

  localparam int DW = l1bp_pkg::DATA_W;
  localparam int SW = l1bp_pkg::SUM_W;
  localparam int PW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [l1bp_pkg::LAM_W-1:0] lam_r;
  logic signed [DW-1:0]       x_r, g_r;
  logic                       last_r;
  logic signed [DW:0]         gp_r, gm_r;
  logic signed [DW:0]         xs, pick, lo, hi;
  l1bp_pkg::cls_t             cls_r, cls_nxt;
  logic signed [DW-1:0]       val_r, val_nxt;
  logic [DW-1:0]              abs_r;
  logic [l1bp_pkg::MAG_W-1:0] mag_r;
  logic [SW-1:0]              sq_r;
  logic [SW-1:0]              beta_sum_r, phi_sum_r;
  logic [SW:0]                beta_add, phi_add;
  logic [PW-1:0]              pos_r;
  logic [CW-1:0]              zero_cnt_r, posc_r, negc_r;
  logic [CW:0]                nz_sum;
  logic [CW-1:0]              nz;
  logic [l1bp_pkg::ROOT_W-1:0] root_beta, root_phi, norm_beta, norm_phi;
  logic                       busy_beta, busy_phi;
  logic                       out_tvalid_r;
  logic [l1bp_pkg::OUT_W-1:0] out_tdata_r;
  logic [l1bp_pkg::CLS_W-1:0] out_tuser_r;
  logic                       out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= '0;
    end else if (cfg_wr_en) begin
      lam_r <= cfg_wr_data;
    end
  end

  // input capture and lambda offsets
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= in_tdata[DW-1:0];
      g_r    <= in_tdata[2*DW-1:DW];
      last_r <= in_tlast;
    end
    if (cmd.prep) begin
      gp_r <= {g_r[DW-1], g_r} + {2'b00, lam_r};
      gm_r <= {g_r[DW-1], g_r} - {2'b00, lam_r};
    end
  end

  // class and step value
  always_comb begin
    xs      = {x_r[DW-1], x_r};
    lo      = (xs < gp_r) ? xs : gp_r;
    hi      = (xs > gm_r) ? xs : gm_r;
    pick    = '0;
    cls_nxt = l1bp_pkg::CLS_UNSEL;
    if (x_r == '0) begin
      if (gp_r < 0) begin
        pick    = gp_r;
        cls_nxt = l1bp_pkg::CLS_ZERO_BETA;
      end else if (gm_r > 0) begin
        pick    = gm_r;
        cls_nxt = l1bp_pkg::CLS_ZERO_BETA;
      end
    end else if (!x_r[DW-1]) begin
      cls_nxt = l1bp_pkg::CLS_POS_PHI;
      pick    = gp_r;
      if (gp_r > 0 && hi < gp_r) begin
        pick = hi;
      end
    end else begin
      cls_nxt = l1bp_pkg::CLS_NEG_PHI;
      pick    = gm_r;
      if (gm_r < 0 && lo > gm_r) begin
        pick = lo;
      end
    end
    if (pick[DW] != pick[DW-1]) begin
      val_nxt = pick[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      val_nxt = pick[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      cls_r <= cls_nxt;
      val_r <= val_nxt;
      abs_r <= val_nxt[DW-1] ? DW'(-val_nxt) : DW'(val_nxt);
    end
    if (cmd.square) begin
      sq_r  <= abs_r * abs_r;
      mag_r <= abs_r[DW-1] ? {l1bp_pkg::MAG_W{1'b1}} : abs_r[l1bp_pkg::MAG_W-1:0];
    end
  end

  assign beta_add = {1'b0, beta_sum_r} + {1'b0, sq_r};
  assign phi_add  = {1'b0, phi_sum_r} + {1'b0, sq_r};

  // sums and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_sum_r <= '0;
      phi_sum_r  <= '0;
      zero_cnt_r <= '0;
      posc_r     <= '0;
      negc_r     <= '0;
      pos_r      <= '0;
    end else if (cmd.accum) begin
      case (cls_r)
        l1bp_pkg::CLS_ZERO_BETA: begin
          beta_sum_r <= beta_add[SW] ? {SW{1'b1}} : beta_add[SW-1:0];
          if (zero_cnt_r < CW'(MAX_ELEMENTS)) zero_cnt_r <= zero_cnt_r + 1'b1;
        end
        l1bp_pkg::CLS_POS_PHI: begin
          phi_sum_r <= phi_add[SW] ? {SW{1'b1}} : phi_add[SW-1:0];
          if (posc_r < CW'(MAX_ELEMENTS)) posc_r <= posc_r + 1'b1;
        end
        l1bp_pkg::CLS_NEG_PHI: begin
          phi_sum_r <= phi_add[SW] ? {SW{1'b1}} : phi_add[SW-1:0];
          if (negc_r < CW'(MAX_ELEMENTS)) negc_r <= negc_r + 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.push) begin
      if (last_r) begin
        beta_sum_r <= '0;
        phi_sum_r  <= '0;
        zero_cnt_r <= '0;
        posc_r     <= '0;
        negc_r     <= '0;
        pos_r      <= '0;
      end else if (pos_r == PW'(MAX_ELEMENTS - 1)) begin
        pos_r <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  assign nz_sum = {1'b0, posc_r} + {1'b0, negc_r};
  assign nz     = (nz_sum > (CW+1)'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : nz_sum[CW-1:0];

  l1bp_isqrt u_root_beta (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.root_start),
    .operand (beta_sum_r),
    .busy    (busy_beta),
    .root    (root_beta)
  );

  l1bp_isqrt u_root_phi (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.root_start),
    .operand (phi_sum_r),
    .busy    (busy_phi),
    .root    (root_phi)
  );

  assign norm_beta = last_r ? root_beta : '0;
  assign norm_phi  = last_r ? root_phi : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_tdata_r <= {1'b0, l1bp_pkg::CNT_W'(nz), l1bp_pkg::CNT_W'(negc_r),
                      l1bp_pkg::CNT_W'(posc_r), l1bp_pkg::CNT_W'(zero_cnt_r),
                      norm_phi, norm_beta, mag_r, val_r, l1bp_pkg::IDX_W'(pos_r)};
      out_tuser_r <= cls_r;
      out_tlast_r <= last_r;
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = out_tdata_r;
  assign out_tuser     = out_tuser_r;
  assign out_tlast     = out_tlast_r;

  assign sts.last      = last_r;
  assign sts.root_done = !busy_beta && !busy_phi;
  assign sts.out_free  = !out_tvalid_r || out_tready;

endmodule

FILE: design/l1bp_ctrl.sv
`timescale 1ns / 1ps
// controller state machine sequencing one element through the datapath
// depends on l1bp_pkg

module l1bp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  l1bp_pkg::ctrl_sts_t sts,
  output l1bp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_SEL    = 7'b0000100,
    S_SQ     = 7'b0001000,
    S_ACC    = 7'b0010000,
    S_ROOT   = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   root_wait_r, root_wait_nxt;

  always_comb begin
    state_nxt      = state_r;
    root_wait_nxt  = root_wait_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.accum     = 1'b1;
        root_wait_nxt = 1'b0;
        state_nxt     = sts.last ? S_ROOT : S_PUSH;
      end
      S_ROOT: begin
        if (!root_wait_r) begin
          cmd.root_start = 1'b1;
          root_wait_nxt  = 1'b1;
        end else if (sts.root_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_wait_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_wait_r <= root_wait_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

FILE: design/l1_beta_phi_split_core.sv
`timescale 1ns / 1ps
// top level of the l1 beta/phi split block: controller plus datapath
// depends on l1bp_pkg, l1bp_ctrl, l1bp_datapath
//
// channel  | direction | payload
// cfg      | in        | cfg_wr_data = lambda, unsigned q15.16
// in       | in        | tdata = coord, grad; tlast = last element
// out      | out       | tdata = index, step, magnitude, norms, counts; tuser = class
//
// a regular element passes the prep, select, square, accumulate and push states to the output register
// the last element of a vector also waits in the root state for the two 32-step square roots
// a new element is accepted as soon as the previous result sits in the output register
// a stalled output holds the next result in the push state until the register frees
// rst_n is synchronous, active low, and clears lambda, sums, counters and control

module l1_beta_phi_split_core #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [l1bp_pkg::LAM_W-1:0]  cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [l1bp_pkg::IN_W-1:0]   in_tdata,   // coord_value, grad_value
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // element_index, step_value, step_magnitude, norm_beta, norm_phi,
  // count_zero_set, count_positive, count_negative, count_nonzero, zero pad
  output logic [l1bp_pkg::OUT_W-1:0]  out_tdata,
  output logic [l1bp_pkg::CLS_W-1:0]  out_tuser,  // class_code
  output logic                        out_tlast
);

  l1bp_pkg::ctrl_cmd_t cmd;
  l1bp_pkg::ctrl_sts_t sts;

  l1bp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  l1bp_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

FILE: design/l1bp_checker.sv
`timescale 1ns / 1ps
// port-level checks for l1_beta_phi_split_core, attached by bind
// depends on l1bp_pkg and l1_beta_phi_split_core

module l1bp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [l1bp_pkg::OUT_W-1:0]  out_tdata,
  input logic [l1bp_pkg::CLS_W-1:0]  out_tuser,
  input logic                        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[138:75] == '0)
    else $error("norms nonzero on non-last transaction");

  a_unsel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == l1bp_pkg::CLS_UNSEL |-> out_tdata[74:12] == '0)
    else $error("unselected element with nonzero step");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind l1_beta_phi_split_core l1bp_checker u_l1bp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: test/l1_beta_phi_split_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for l1_beta_phi_split_core: streams vector elements, predicts
// class, step, norms and counts in a scoreboard class and checks every out transaction
// depends on l1bp_pkg and l1_beta_phi_split_core

module l1_beta_phi_split_core_tb;
  import l1bp_pkg::*;

  localparam int VEC_MAX = 4096;
  localparam int RANDOM_ITEMS = 1650;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0]  index;
    cls_t              cls;
    logic [DATA_W-1:0] step;
    logic [MAG_W-1:0]  magnitude;
    logic              last;
    logic [ROOT_W-1:0] norm_beta;
    logic [ROOT_W-1:0] norm_phi;
    logic [CNT_W-1:0]  n_zero;
    logic [CNT_W-1:0]  n_pos;
    logic [CNT_W-1:0]  n_neg;
    logic [CNT_W-1:0]  n_nonzero;
  } step_result_t;

  class beta_phi_scoreboard;
    step_result_t expected_steps[$];
    logic [LAM_W-1:0] weight;
    logic [SUM_W-1:0] beta_acc;
    logic [SUM_W-1:0] phi_acc;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] zero_cnt;
    logic [CNT_W-1:0] pos_cnt;
    logic [CNT_W-1:0] neg_cnt;
    int errors;

    function new();
      weight = '0;
      errors = 0;
      clear_vector();
    endfunction

    function void clear_vector();
      beta_acc = '0;
      phi_acc = '0;
      position = '0;
      zero_cnt = '0;
      pos_cnt = '0;
      neg_cnt = '0;
    endfunction

    function void set_weight(logic [LAM_W-1:0] w);
      weight = w;
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction

    function logic [SUM_W-1:0] acc_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
      logic [SUM_W:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[SUM_W] ? '1 : wide[SUM_W-1:0];
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c < VEC_MAX) ? c + 1'b1 : c;
    endfunction

    function logic [ROOT_W-1:0] root64(logic [SUM_W-1:0] n);
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] res;
      logic [SUM_W-1:0] bitv;
      rem = n;
      res = '0;
      bitv = 64'h1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res[ROOT_W-1:0];
    endfunction

    function void note_element(logic [DATA_W-1:0] coord, logic [DATA_W-1:0] grad,
                               logic last);
      longint x;
      longint g;
      longint lam;
      longint v;
      longint lim;
      logic [63:0] mag;
      logic [SUM_W-1:0] sq;
      logic [CNT_W:0] nz;
      cls_t c;
      step_result_t r;
      x = $signed(coord);
      g = $signed(grad);
      lam = weight;
      if (x == 0) begin
        if (g < -lam) begin
          v = g + lam;
          c = CLS_ZERO_BETA;
        end else if (g > lam) begin
          v = g - lam;
          c = CLS_ZERO_BETA;
        end else begin
          v = 0;
          c = CLS_UNSEL;
        end
      end else if (x > 0) begin
        v = g + lam;
        if (v > 0) begin
          lim = (x > g - lam) ? x : g - lam;
          v = (v < lim) ? v : lim;
        end
        c = CLS_POS_PHI;
      end else begin
        v = g - lam;
        if (v < 0) begin
          lim = (x < g + lam) ? x : g + lam;
          v = (v > lim) ? v : lim;
        end
        c = CLS_NEG_PHI;
      end
      if (v > S32_MAX) v = S32_MAX;
      if (v < S32_MIN) v = S32_MIN;
      mag = (v < 0) ? -v : v;
      if (mag > 64'h7fff_ffff) mag = 64'h7fff_ffff;
      sq = (v == S32_MIN) ? 64'h4000_0000_0000_0000 : mag * mag;

      case (c)
        CLS_ZERO_BETA: begin
          beta_acc = acc_add(beta_acc, sq);
          zero_cnt = bump(zero_cnt);
        end
        CLS_POS_PHI: begin
          phi_acc = acc_add(phi_acc, sq);
          pos_cnt = bump(pos_cnt);
        end
        CLS_NEG_PHI: begin
          phi_acc = acc_add(phi_acc, sq);
          neg_cnt = bump(neg_cnt);
        end
        default: ;
      endcase
      nz = pos_cnt + neg_cnt;
      if (nz > VEC_MAX) nz = VEC_MAX;

      r.index = position;
      r.cls = c;
      r.step = v[DATA_W-1:0];
      r.magnitude = mag[MAG_W-1:0];
      r.last = last;
      r.norm_beta = last ? root64(beta_acc) : '0;
      r.norm_phi = last ? root64(phi_acc) : '0;
      r.n_zero = zero_cnt;
      r.n_pos = pos_cnt;
      r.n_neg = neg_cnt;
      r.n_nonzero = nz[CNT_W-1:0];
      expected_steps.push_back(r);

      if (last) begin
        clear_vector();
      end else begin
        position = (position == VEC_MAX - 1) ? '0 : position + 1'b1;
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_step(step_result_t got);
      step_result_t want;
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected out transaction, expected none, actual index %0h",
                 $time, got.index);
        errors++;
        return;
      end
      want = expected_steps.pop_front();
      check_field("element_index", want.index, got.index);
      check_field("class_code", want.cls, got.cls);
      check_field("step_value", want.step, got.step);
      check_field("step_magnitude", want.magnitude, got.magnitude);
      check_field("last_out", want.last, got.last);
      check_field("norm_beta", want.norm_beta, got.norm_beta);
      check_field("norm_phi", want.norm_phi, got.norm_phi);
      check_field("count_zero_set", want.n_zero, got.n_zero);
      check_field("count_positive", want.n_pos, got.n_pos);
      check_field("count_negative", want.n_neg, got.n_neg);
      check_field("count_nonzero", want.n_nonzero, got.n_nonzero);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [LAM_W-1:0]  cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // coord_value, grad_value
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  // element_index, step_value, step_magnitude, norm_beta, norm_phi,
  // count_zero_set, count_positive, count_negative, count_nonzero, zero pad
  logic [OUT_W-1:0]  out_tdata;
  logic [CLS_W-1:0]  out_tuser;  // class_code
  logic              out_tlast;

  beta_phi_scoreboard ledger;
  step_result_t seen;
  int tx_idle_pct;
  int rx_idle_pct;

  l1_beta_phi_split_core #(
    .MAX_ELEMENTS(VEC_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.index = out_tdata[11:0];
      seen.step = out_tdata[43:12];
      seen.magnitude = out_tdata[74:44];
      seen.norm_beta = out_tdata[106:75];
      seen.norm_phi = out_tdata[138:107];
      seen.n_zero = out_tdata[151:139];
      seen.n_pos = out_tdata[164:152];
      seen.n_neg = out_tdata[177:165];
      seen.n_nonzero = out_tdata[190:178];
      seen.cls = cls_t'(out_tuser);
      seen.last = out_tlast;
      ledger.check_step(seen);
    end
  end

  task automatic send_element(input logic [DATA_W-1:0] coord, input logic [DATA_W-1:0] grad,
                              input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {grad, coord};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    ledger.note_element(coord, grad, last);
  endtask

  // lambda only changes with the pipe drained
  task automatic load_weight(input logic [LAM_W-1:0] w);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (48) @(negedge clk);
    cfg_wr_data <= w;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ledger.set_weight(w);
  endtask

  function automatic logic [DATA_W-1:0] pick_word(logic [LAM_W-1:0] lam);
    logic [DATA_W-1:0] near;
    logic [DATA_W-1:0] tiny;
    near = {1'b0, lam} + 32'($urandom_range(4)) - 32'd2;
    tiny = 32'($urandom_range(0, 32'h40000));
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return near;
      3: return -near;
      4, 5: return $urandom_range(1) ? tiny : -tiny;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [LAM_W-1:0] pick_lambda();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'h7fff_ffff;
      2: return 31'd1;
      3: return 31'h1_0000;
      4: return 31'($urandom_range(0, 32'h8_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_random_vector(input int len);
    logic [DATA_W-1:0] x;
    for (int i = 0; i < len; i++) begin
      x = ($urandom_range(9) < 3) ? 32'd0 : pick_word(ledger.weight);
      send_element(x, pick_word(ledger.weight), i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int vectors;
    int len;
    ledger = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 69;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // most negative steps, beta then phi sums saturate
    load_weight('0);
    send_element(32'd0, 32'd0, 1'b0);
    for (int i = 0; i < 5; i++) send_element(32'd0, 32'h8000_0000, i == 4);
    for (int i = 0; i < 5; i++) send_element(32'hffff_ffff, 32'h8000_0000, i == 4);

    load_weight(31'h7fff_ffff);
    send_element(32'd0, 32'h7fff_ffff, 1'b0);
    send_element(32'd0, 32'h8000_0000, 1'b0);
    send_element(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_element(32'd1, 32'h8000_0000, 1'b0);
    send_element(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_element(32'hffff_ffff, 32'h8000_0000, 1'b1);

    load_weight(31'h1_0000);
    send_element(32'd0, 32'h0001_0001, 1'b0);
    send_element(32'd0, 32'hfffe_ffff, 1'b0);
    send_element(32'd0, 32'h0001_0000, 1'b0);
    send_element(32'h0000_0005, 32'h0003_0000, 1'b0);
    send_element(32'hffff_fffb, 32'hfffd_0000, 1'b0);
    send_element(32'h0002_0000, 32'hfffe_8000, 1'b1);

    sent = 0;
    vectors = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 10;
        rx_idle_pct = 69;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (vectors % 12 == 0) load_weight(pick_lambda());
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      send_random_vector(len);
      sent += len;
      vectors++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
design/l1bp_pkg.sv
design/l1bp_isqrt.sv
design/l1bp_datapath.sv
design/l1bp_ctrl.sv
design/l1_beta_phi_split_core.sv
design/l1bp_checker.sv
test/l1_beta_phi_split_core_tb.sv
